[hw/rtl/spb_pkg.sv]
// Shared types and codes for the slot pool buffer.
`timescale 1ns / 1ps

package spb_pkg;

   // Request codes
   localparam logic [2:0] REQ_PUT_SCAN = 3'd0;
   localparam logic [2:0] REQ_PUT_SLOT = 3'd1;
   localparam logic [2:0] REQ_GET_SCAN = 3'd2;
   localparam logic [2:0] REQ_GET_SLOT = 3'd3;
   localparam logic [2:0] REQ_RECYCLE  = 3'd4;

   // Status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;
   localparam logic [1:0] STAT_RANGE = 2'd3;

   localparam int unsigned TYPE_BITS  = 3;
   localparam int unsigned INDEX_BITS = 4;
   localparam int unsigned COUNT_BITS = 5;

   typedef enum logic [1:0] {
      MARK_FREE     = 2'd0,
      MARK_READY    = 2'd1,
      MARK_RECYCLED = 2'd2
   } mark_type;

   typedef enum logic [3:0] {
      ST_COUNT  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_STEP   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   // Result control from the sequencer to the output stage
   typedef struct packed {
      logic                  done;
      logic [1:0]            status;
      logic [INDEX_BITS-1:0] slot;
      logic                  get_ok;
   } rsp_ctl_type;

endpackage

[hw/rtl/spb_store.sv]
// Data word memory of the slot pool, one write and one registered read per cycle.
`timescale 1ns / 1ps

module spb_store #(
   parameter int unsigned MAX_SLOTS = 16,
   parameter int unsigned DATA_BITS = 32
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(MAX_SLOTS)-1:0] addr,
   input  logic [DATA_BITS-1:0]         wr_data,
   output logic [DATA_BITS-1:0]         rd_data_ff
);

   logic [DATA_BITS-1:0] mem [MAX_SLOTS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

endmodule

[hw/rtl/spb_ctrl.sv]
// Sequencer, slot marks and occupancy counters of the slot pool.
`timescale 1ns / 1ps

module spb_ctrl #(
   parameter int unsigned MAX_SLOTS = 16,
   parameter int unsigned DATA_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [spb_pkg::TYPE_BITS-1:0]         req_type,
   input  logic [spb_pkg::INDEX_BITS-1:0]        req_slot_index,
   input  logic [DATA_BITS-1:0]                  req_write_data,
   input  logic [$clog2(MAX_SLOTS+1)-1:0]        active_slots,
   input  logic                                  csr_we,
   output logic                                  busy,
   output logic                                  store_we,
   output logic [$clog2(MAX_SLOTS)-1:0]          store_addr,
   output logic [DATA_BITS-1:0]                  store_wdata,
   output spb_pkg::rsp_ctl_type                  rsp_ctl,
   output logic [$clog2(MAX_SLOTS+1)-1:0]        ready_cnt,
   output logic [$clog2(MAX_SLOTS+1)-1:0]        free_cnt
);

   import spb_pkg::*;

   localparam int unsigned SlotBits = $clog2(MAX_SLOTS);
   localparam int unsigned CntBits  = $clog2(MAX_SLOTS + 1);

   state_type              state_ff, state_in;
   logic [CntBits-1:0]     ptr_ff, ptr_in;
   logic [CntBits-1:0]     rdy_ff, rdy_in;
   logic [CntBits-1:0]     free_ff, free_in;
   mark_type               mark_ff [MAX_SLOTS];
   logic                   mark_we;
   mark_type               mark_wdata;
   logic [TYPE_BITS-1:0]   type_ff, type_in;
   logic [DATA_BITS-1:0]   data_ff, data_in;
   logic [1:0]             status_ff, status_in;
   logic [INDEX_BITS-1:0]  slot_ff, slot_in;
   logic                   get_ok_ff, get_ok_in;
   mark_type               cur_mark;
   logic                   at_end;
   logic                   is_open;
   logic                   is_ready;

   always_comb begin
      cur_mark  = mark_ff[ptr_ff[SlotBits-1:0]];
      at_end    = (ptr_ff >= active_slots);
      is_ready  = (cur_mark == MARK_READY);
      is_open   = (cur_mark == MARK_FREE) || (cur_mark == MARK_RECYCLED);

      state_in   = state_ff;
      ptr_in     = ptr_ff;
      rdy_in     = rdy_ff;
      free_in    = free_ff;
      type_in    = type_ff;
      data_in    = data_ff;
      status_in  = status_ff;
      slot_in    = slot_ff;
      get_ok_in  = get_ok_ff;
      mark_we    = 1'b0;
      mark_wdata = MARK_READY;
      store_we   = 1'b0;

      unique case (state_ff)
         ST_COUNT: begin
            // recount the slots in use, one mark per cycle
            if (at_end) begin
               state_in = ST_IDLE;
            end else begin
               if (is_ready) begin
                  rdy_in = rdy_ff + CntBits'(1);
               end else if (is_open) begin
                  free_in = free_ff + CntBits'(1);
               end
               ptr_in = ptr_ff + CntBits'(1);
            end
         end
         ST_IDLE: begin
            if (start) begin
               type_in   = req_type;
               data_in   = req_write_data;
               ptr_in    = CntBits'(req_slot_index);
               slot_in   = req_slot_index;
               status_in = STAT_OK;
               get_ok_in = 1'b0;
               if (req_type > REQ_RECYCLE) begin
                  state_in = ST_FINISH;
               end else if (32'(req_slot_index) >= 32'(active_slots)) begin
                  status_in = STAT_RANGE;
                  state_in  = ST_FINISH;
               end else begin
                  state_in = ST_STEP;
               end
            end
         end
         ST_STEP: begin
            unique case (type_ff)
               REQ_PUT_SCAN: begin
                  if (at_end) begin
                     status_in = STAT_FULL;
                     state_in  = ST_FINISH;
                  end else if (is_open) begin
                     mark_we    = 1'b1;
                     mark_wdata = MARK_READY;
                     store_we   = 1'b1;
                     slot_in    = INDEX_BITS'(ptr_ff);
                     rdy_in     = rdy_ff + CntBits'(1);
                     free_in    = free_ff - CntBits'(1);
                     state_in   = ST_FINISH;
                  end else begin
                     ptr_in = ptr_ff + CntBits'(1);
                  end
               end
               REQ_PUT_SLOT: begin
                  if (is_open) begin
                     mark_we    = 1'b1;
                     mark_wdata = MARK_READY;
                     store_we   = 1'b1;
                     rdy_in     = rdy_ff + CntBits'(1);
                     free_in    = free_ff - CntBits'(1);
                  end else begin
                     status_in = STAT_FULL;
                  end
                  state_in = ST_FINISH;
               end
               REQ_GET_SCAN: begin
                  if (at_end || (cur_mark == MARK_FREE)) begin
                     status_in = STAT_EMPTY;
                     slot_in   = '0;
                     state_in  = ST_FINISH;
                  end else if (is_ready) begin
                     mark_we    = 1'b1;
                     mark_wdata = MARK_RECYCLED;
                     get_ok_in  = 1'b1;
                     slot_in    = INDEX_BITS'(ptr_ff);
                     rdy_in     = rdy_ff - CntBits'(1);
                     free_in    = free_ff + CntBits'(1);
                     state_in   = ST_FINISH;
                  end else begin
                     ptr_in = ptr_ff + CntBits'(1);
                  end
               end
               REQ_GET_SLOT, REQ_RECYCLE: begin
                  if (is_ready) begin
                     mark_we    = 1'b1;
                     mark_wdata = MARK_RECYCLED;
                     get_ok_in  = (type_ff == REQ_GET_SLOT);
                     rdy_in     = rdy_ff - CntBits'(1);
                     free_in    = free_ff + CntBits'(1);
                  end else begin
                     status_in = STAT_EMPTY;
                  end
                  state_in = ST_FINISH;
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a new slot count invalidates both counters: sweep again
      if (csr_we) begin
         state_in = ST_COUNT;
         ptr_in   = '0;
         rdy_in   = '0;
         free_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COUNT;
         ptr_ff   <= '0;
         rdy_ff   <= '0;
         free_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
         rdy_ff   <= rdy_in;
         free_ff  <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_SLOTS; i++) begin
            mark_ff[i] <= MARK_FREE;
         end
      end else if (mark_we) begin
         mark_ff[ptr_ff[SlotBits-1:0]] <= mark_wdata;
      end
   end

   always_ff @(posedge clock) begin
      type_ff   <= type_in;
      data_ff   <= data_in;
      status_ff <= status_in;
      slot_ff   <= slot_in;
      get_ok_ff <= get_ok_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign store_addr     = ptr_ff[SlotBits-1:0];
   assign store_wdata    = data_ff;
   assign rsp_ctl.done   = (state_ff == ST_FINISH);
   assign rsp_ctl.status = status_ff;
   assign rsp_ctl.slot   = slot_ff;
   assign rsp_ctl.get_ok = get_ok_ff;
   assign ready_cnt      = rdy_ff;
   assign free_cnt       = free_ff;

endmodule

[hw/rtl/slot_pool_buffer.sv]
// Top level of the slot pool buffer: slot count register, sequencer, store, result stage.
`timescale 1ns / 1ps

// Usage:
//   Present a request on req_type, req_slot_index and req_write_data with start
//   high; it is taken at the rising edge where start is high and busy is low.
//   Request types: put scan, put at slot, get scan, get at slot, recycle slot.
//   Each request gives one result, shown on the rsp_ ports for one cycle while
//   rsp_valid is high. The receiver cannot stall; every result must be taken.
//   A request with an out-of-range index or an unknown type goes from idle
//   straight to the finish state; a slot request passes the step state, then
//   the finish state; a scan stays in the step state until it finds a slot,
//   reaches slots_in_use or, for a get scan, meets a free slot, examining one
//   mark per cycle by the shared compare step. busy falls in the same cycle
//   that rsp_valid rises, so the next request may be taken at the edge that
//   ends the result cycle.
//   csr_we/csr_wdata set slots_in_use (values above MAX_SLOTS act as MAX_SLOTS).
//   Write it only while idle; each write starts a recount sweep over the
//   slots in use during which busy stays high.
//   Reset marks every slot free, sets slots_in_use to min(16, MAX_SLOTS) and
//   runs the same recount sweep before the first request.
module slot_pool_buffer #(
   parameter int unsigned MAX_SLOTS = 16,
   parameter int unsigned DATA_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              start,
   output logic                              busy,
   input  logic [spb_pkg::TYPE_BITS-1:0]     req_type,
   input  logic [spb_pkg::INDEX_BITS-1:0]    req_slot_index,
   input  logic [DATA_BITS-1:0]              req_write_data,
   // result channel
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_status,
   output logic [spb_pkg::INDEX_BITS-1:0]    rsp_slot_out,
   output logic [DATA_BITS-1:0]              rsp_read_data,
   output logic [spb_pkg::COUNT_BITS-1:0]    rsp_ready_count,
   output logic [spb_pkg::COUNT_BITS-1:0]    rsp_free_count,
   // slot count register
   input  logic                              csr_we,
   input  logic [spb_pkg::COUNT_BITS-1:0]    csr_wdata
);

   import spb_pkg::*;

   localparam int unsigned SlotBits    = $clog2(MAX_SLOTS);
   localparam int unsigned CntBits     = $clog2(MAX_SLOTS + 1);
   localparam int unsigned ResetActive = (MAX_SLOTS < 16) ? MAX_SLOTS : 16;

   logic [CntBits-1:0]     active_ff, active_in;
   logic                   store_we;
   logic [SlotBits-1:0]    store_addr;
   logic [DATA_BITS-1:0]   store_wdata;
   logic [DATA_BITS-1:0]   store_rdata;
   rsp_ctl_type            rsp_ctl;
   logic [CntBits-1:0]     ready_cnt;
   logic [CntBits-1:0]     free_cnt;

   logic                   rsp_valid_ff;
   logic [1:0]             rsp_status_ff;
   logic [INDEX_BITS-1:0]  rsp_slot_ff;
   logic [DATA_BITS-1:0]   rsp_data_ff, rsp_data_in;
   logic [COUNT_BITS-1:0]  rsp_ready_ff;
   logic [COUNT_BITS-1:0]  rsp_free_ff;

   // Clamp the slot count to the pool size as it is written
   always_comb begin
      active_in = active_ff;
      if (csr_we) begin
         if (32'(csr_wdata) > MAX_SLOTS) begin
            active_in = CntBits'(MAX_SLOTS);
         end else begin
            active_in = CntBits'(csr_wdata);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= CntBits'(ResetActive);
      end else begin
         active_ff <= active_in;
      end
   end

   spb_ctrl #(
      .MAX_SLOTS (MAX_SLOTS),
      .DATA_BITS (DATA_BITS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_type       (req_type),
      .req_slot_index (req_slot_index),
      .req_write_data (req_write_data),
      .active_slots   (active_ff),
      .csr_we         (csr_we),
      .busy           (busy),
      .store_we       (store_we),
      .store_addr     (store_addr),
      .store_wdata    (store_wdata),
      .rsp_ctl        (rsp_ctl),
      .ready_cnt      (ready_cnt),
      .free_cnt       (free_cnt)
   );

   spb_store #(
      .MAX_SLOTS (MAX_SLOTS),
      .DATA_BITS (DATA_BITS)
   ) u_store (
      .clock      (clock),
      .wr_en      (store_we),
      .addr       (store_addr),
      .wr_data    (store_wdata),
      .rd_data_ff (store_rdata)
   );

   // Drop the store output unless a get found a ready slot
   assign rsp_data_in = rsp_ctl.get_ok ? store_rdata : '0;

   // Result stage: strobe for one cycle, hold fields until the next result
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_ctl.done;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_ctl.done) begin
         rsp_status_ff <= rsp_ctl.status;
         rsp_slot_ff   <= rsp_ctl.slot;
         rsp_data_ff   <= rsp_data_in;
         rsp_ready_ff  <= COUNT_BITS'(ready_cnt);
         rsp_free_ff   <= COUNT_BITS'(free_cnt);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot_out    = rsp_slot_ff;
   assign rsp_read_data   = rsp_data_ff;
   assign rsp_ready_count = rsp_ready_ff;
   assign rsp_free_count  = rsp_free_ff;

endmodule
